@@ src/rmcr_pkg.sv @@
// Package for the radio motor command responder: item structs, command codes,
// register indexes, reply layout constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rmcr_pkg;

  // One input item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sender;
    logic [7:0] command;
    logic [7:0] argument;
    logic [2:0] adc_channel;
    logic [7:0] adc_high;
    logic [7:0] adc_low;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [4:0] motor_lines;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_item_t;

  // Item kinds.
  localparam logic [1:0] KIND_COMMAND  = 2'd0;
  localparam logic [1:0] KIND_TICK     = 2'd1;
  localparam logic [1:0] KIND_ADC      = 2'd2;
  localparam logic [1:0] KIND_TRANSMIT = 2'd3;

  // ASCII command bytes.
  localparam logic [7:0] CMD_VERSION = 8'h56;  // 'V'
  localparam logic [7:0] CMD_ECHO    = 8'h45;  // 'E'
  localparam logic [7:0] CMD_MOTOR   = 8'h4D;  // 'M'
  localparam logic [7:0] CMD_STATUS  = 8'h53;  // 'S'
  localparam logic [7:0] CMD_ACK     = 8'h41;  // 'A'
  localparam logic [7:0] CMD_DUMP    = 8'h44;  // 'D'

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_MOTOR_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PROTO_VERSION = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] OWN_ADDRESS_RST   = 8'd0;
  localparam logic [7:0] MOTOR_TIMEOUT_RST = 8'd10;
  localparam logic [7:0] PROTO_VERSION_RST = 8'd1;

  localparam logic [4:0] MOTOR_MASK = 5'h1f;

  // Reply layout.
  localparam int         REPLY_DEPTH = 13;
  localparam logic [3:0] REPLY_MAX   = 4'd13;
  localparam logic [3:0] LEN_ECHO    = 4'd3;
  localparam logic [3:0] LEN_STATUS  = 4'd4;
  localparam logic [3:0] LEN_DUMP    = 4'd13;
  localparam logic [3:0] ADC_REPORT  = 4'd10;

  // Request from the sequencer to the ADC sample store.
  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_chan;
    logic [7:0] wr_high;
    logic [7:0] wr_low;
    logic       rd_en;
    logic [3:0] rd_byte;
  } adc_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_WR,
    ST_D_COPY,
    ST_EMIT,
    ST_TX_LEN,
    ST_TX_BYTE
  } rmcr_state_t;

endpackage

@@ src/rmcr_adc_store.sv @@
// ADC sample store: one row of high and low byte per channel, with a valid
// bit per row so that unwritten bytes read as zero. Depends on rmcr_pkg.
`timescale 1ns / 1ps

module rmcr_adc_store #(
  parameter int ADC_CHANNELS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rmcr_pkg::adc_req_t req,
  output logic [7:0]        rd_data
);
  import rmcr_pkg::*;

  localparam int ROW_W = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;

  logic [15:0]             mem [ADC_CHANNELS];
  logic [ADC_CHANNELS-1:0] vld_r;
  logic [15:0]             row_r;
  logic                    ok_r;
  logic                    sel_r;

  logic                    wr_hit;
  logic [2:0]              rd_row;
  logic                    rd_hit;
  logic                    rd_ok;

  assign wr_hit = req.wr_en && ({2'b00, req.wr_chan} < 5'(ADC_CHANNELS));
  assign rd_row = req.rd_byte[3:1];
  assign rd_hit = {2'b00, rd_row} < 5'(ADC_CHANNELS);
  assign rd_ok  = rd_hit ? vld_r[ROW_W'(rd_row)] : 1'b0;

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[ROW_W'(req.wr_chan)] <= {req.wr_high, req.wr_low};
    end
    if (req.rd_en && rd_hit) begin
      row_r <= mem[ROW_W'(rd_row)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok_r  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld_r[ROW_W'(req.wr_chan)] <= 1'b1;
      end
      if (req.rd_en) begin
        ok_r  <= rd_ok;
        sel_r <= req.rd_byte[0];
      end
    end
  end

  // Even byte index is the high byte of the channel.
  assign rd_data = ok_r ? (sel_r ? row_r[7:0] : row_r[15:8]) : 8'h00;

endmodule

@@ src/radio_motor_command_responder_unit.sv @@
// Radio motor command responder, top level: sequencer, reply buffer memory,
// configuration registers and output register. Depends on rmcr_pkg and
// rmcr_adc_store.
// Tick, ADC and non-building items pass from idle to the emit state and give
// their result from there; E and V/S/M replies take 3 or 4 buffer writes first,
// D takes 3 writes plus a copy of ten ADC bytes from the ADC store.
// A transmit gives its length byte first and then one byte per cycle while
// the output side takes them.
// One item is worked on at a time; the next is accepted once the sequencer
// is back in idle.
// Reset is synchronous and active low; it clears all control state and the
// ADC row valid bits, so the ADC store reads as zero. The reply buffer is
// not cleared; it is only read after a reply has written it.
`timescale 1ns / 1ps

module radio_motor_command_responder_unit #(
  parameter int ADC_CHANNELS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmcr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rmcr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import rmcr_pkg::*;

  // Configuration registers.
  logic [7:0] own_addr_r;
  logic [7:0] timeout_r;
  logic [7:0] version_r;

  // Control state.
  rmcr_state_t state_r, state_nxt;
  logic [4:0]  motor_r, motor_nxt;
  logic [7:0]  countdown_r, countdown_nxt;
  logic [3:0]  reply_len_r, reply_len_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [3:0]  tx_n_r, tx_n_nxt;
  logic [7:0]  sender_r, sender_nxt;
  logic [7:0]  cmd_r, cmd_nxt;

  // Output register.
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        out_load;
  out_item_t   out_nxt;
  logic        slot_free;

  // Reply buffer memory: one write and one registered read port.
  logic [7:0]  reply_mem [REPLY_DEPTH];
  logic        rb_we;
  logic [3:0]  rb_waddr;
  logic [7:0]  rb_wdata;
  logic        rb_re;
  logic [3:0]  rb_raddr;
  logic [7:0]  rb_rdata_r;

  // ADC store.
  adc_req_t    adc_req;
  logic [7:0]  adc_rd_data;

  logic        builds;
  logic [3:0]  clamp_len;

  rmcr_adc_store #(
    .ADC_CHANNELS(ADC_CHANNELS)
  ) u_adc_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (adc_req),
    .rd_data(adc_rd_data)
  );

  // The output register takes a new result whenever it is empty or its
  // current result leaves in the same cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_ready  = (state_r == ST_IDLE);

  // A command builds a reply only when none is pending and it is one of the
  // reply-producing commands.
  always_comb begin
    builds = 1'b0;
    if (reply_len_r == 4'd0) begin
      builds = (in_item.command == CMD_VERSION) || (in_item.command == CMD_ECHO) ||
               (in_item.command == CMD_MOTOR)   || (in_item.command == CMD_STATUS) ||
               (in_item.command == CMD_DUMP);
    end
    clamp_len = (reply_len_r > REPLY_MAX) ? REPLY_MAX : reply_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDRESS_RST;
      timeout_r  <= MOTOR_TIMEOUT_RST;
      version_r  <= PROTO_VERSION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:   own_addr_r <= cfg_wdata;
        REG_MOTOR_TIMEOUT: timeout_r  <= cfg_wdata;
        REG_PROTO_VERSION: version_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      motor_r     <= '0;
      countdown_r <= '0;
      reply_len_r <= '0;
      step_r      <= '0;
      tx_n_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      motor_r     <= motor_nxt;
      countdown_r <= countdown_nxt;
      reply_len_r <= reply_len_nxt;
      step_r      <= step_nxt;
      tx_n_r      <= tx_n_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    sender_r <= sender_nxt;
    cmd_r    <= cmd_nxt;
    if (out_load) begin
      out_item_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rb_we) begin
      reply_mem[rb_waddr] <= rb_wdata;
    end
    if (rb_re) begin
      rb_rdata_r <= reply_mem[rb_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    motor_nxt     = motor_r;
    countdown_nxt = countdown_r;
    reply_len_nxt = reply_len_r;
    step_nxt      = step_r;
    tx_n_nxt      = tx_n_r;
    sender_nxt    = sender_r;
    cmd_nxt       = cmd_r;
    out_load      = 1'b0;
    out_nxt       = '{motor_lines: motor_r, tx_valid: 1'b0, tx_byte: 8'h00, tx_last: 1'b0};
    rb_we         = 1'b0;
    rb_waddr      = step_r;
    rb_wdata      = own_addr_r;
    rb_re         = 1'b0;
    rb_raddr      = step_r;
    adc_req       = '{wr_en: 1'b0, wr_chan: in_item.adc_channel, wr_high: in_item.adc_high,
                      wr_low: in_item.adc_low, rd_en: 1'b0, rd_byte: step_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          step_nxt = 4'd0;
          unique case (in_item.kind)
            KIND_COMMAND: begin
              sender_nxt = in_item.sender;
              cmd_nxt    = in_item.command;
              if (in_item.command == CMD_ACK) begin
                reply_len_nxt = 4'd0;
              end
              if (in_item.command == CMD_MOTOR) begin
                motor_nxt     = in_item.argument[4:0] & MOTOR_MASK;
                countdown_nxt = timeout_r;
              end
              state_nxt = builds ? ST_CMD_WR : ST_EMIT;
            end
            KIND_TICK: begin
              if (countdown_r != 8'd0) begin
                countdown_nxt = countdown_r - 8'd1;
                if (countdown_r == 8'd1) begin
                  motor_nxt = '0;
                end
              end
              state_nxt = ST_EMIT;
            end
            KIND_ADC: begin
              adc_req.wr_en = 1'b1;
              state_nxt     = ST_EMIT;
            end
            KIND_TRANSMIT: begin
              tx_n_nxt  = clamp_len;
              state_nxt = (clamp_len == 4'd0) ? ST_EMIT : ST_TX_LEN;
            end
            default: ;
          endcase
        end
      end

      // Header and command bytes, one buffer write per cycle.
      ST_CMD_WR: begin
        rb_we    = 1'b1;
        step_nxt = step_r + 4'd1;
        unique case (step_r[1:0])
          2'd0: rb_wdata = own_addr_r;
          2'd1: rb_wdata = sender_r;
          2'd2: rb_wdata = (cmd_r == CMD_MOTOR) ? CMD_STATUS : cmd_r;
          2'd3: rb_wdata = (cmd_r == CMD_VERSION) ? version_r : {3'b000, motor_r};
          default: ;
        endcase
        if (step_r == 4'd2 && cmd_r == CMD_ECHO) begin
          reply_len_nxt = LEN_ECHO;
          state_nxt     = ST_EMIT;
        end else if (step_r == 4'd2 && cmd_r == CMD_DUMP) begin
          step_nxt  = 4'd0;
          state_nxt = ST_D_COPY;
        end else if (step_r == 4'd3) begin
          reply_len_nxt = LEN_STATUS;
          state_nxt     = ST_EMIT;
        end
      end

      // ADC byte j is read in step j and written to reply entry j + 3 in
      // the step after.
      ST_D_COPY: begin
        step_nxt = step_r + 4'd1;
        if (step_r < ADC_REPORT) begin
          adc_req.rd_en = 1'b1;
        end
        if (step_r != 4'd0) begin
          rb_we    = 1'b1;
          rb_waddr = step_r + 4'd2;
          rb_wdata = adc_rd_data;
        end
        if (step_r == ADC_REPORT) begin
          reply_len_nxt = LEN_DUMP;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_TX_LEN: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_nxt.tx_valid = 1'b1;
          out_nxt.tx_byte  = {4'b0000, tx_n_r};
          rb_re            = 1'b1;
          rb_raddr         = 4'd0;
          step_nxt         = 4'd0;
          state_nxt        = ST_TX_BYTE;
        end
      end

      // The read data register only moves on a read, so a stalled output
      // keeps the byte in hand.
      ST_TX_BYTE: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_nxt.tx_valid = 1'b1;
          out_nxt.tx_byte  = rb_rdata_r;
          out_nxt.tx_last  = (step_r == tx_n_r - 4'd1);
          if (step_r == tx_n_r - 4'd1) begin
            state_nxt = ST_IDLE;
          end else begin
            rb_re    = 1'b1;
            rb_raddr = step_r + 4'd1;
            step_nxt = step_r + 4'd1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // A new result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  // The byte counter stays inside the reply while it is sent.
  a_tx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TX_BYTE) |-> (step_r < tx_n_r))
    else $error("transmit counter beyond reply length");

  // Only one item at a time is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // The final-byte flag comes only from the reply byte stage.
  a_last_from_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.tx_last) |-> (state_r == ST_TX_BYTE))
    else $error("last flag outside a transmit");

endmodule

@@ tb/radio_motor_command_responder_unit_tb.sv @@
// Self-checking testbench for radio_motor_command_responder_unit: a directed
// table followed by constrained-looking random item sequences, all checked
// against an in-bench prediction of the responder. Depends on rmcr_pkg.
`timescale 1ns / 1ps

module radio_motor_command_responder_unit_tb;
  import rmcr_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int ADC_CHANNELS = 5;
  localparam int ADC_BYTES    = 2 * ADC_CHANNELS;
  // Cycles without any accepted item, on either side, before the run is
  // declared hung. The slowest legal stretch is a config pause plus a sender
  // gap plus a D copy plus a receiver stall.
  localparam int QUIET_LIMIT  = 2000;
  // Settling time after the last result, before a register write or the end.
  localparam int DRAIN_CYCLES = 40;
  localparam logic [3:0] LEN_VERSION = 4'd4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_OWN_ADDRESS;
  logic [7:0] cfg_wdata = 8'h00;

  radio_motor_command_responder_unit #(
    .ADC_CHANNELS(ADC_CHANNELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the responder: its registers and its internal state.
  // Everything here is updated at the clock edge where an item or a register
  // write is taken by the block.
  logic [7:0] own_addr_reg;
  logic [7:0] timeout_reg;
  logic [7:0] version_reg;
  logic [4:0] motor_lines_now;
  logic [7:0] ticks_to_disable;
  logic [3:0] reply_len;
  logic [7:0] reply_bytes [REPLY_DEPTH];
  logic [7:0] adc_bytes [ADC_BYTES];

  // Bytes and status results the block still owes us, oldest first.
  out_item_t responses_due [$];

  int fail_count  = 0;
  int quiet_count = 0;
  int burst_left  = 0;

  // Receiver pattern state.
  int  rx_cycle   = 0;
  int  stall_left = 0;
  bit  rx_free    = 1'b0;

  // One row of the directed table. When typed is set, the row carries its
  // own expected motor lines for a single idle result, read straight off the
  // spec; otherwise the prediction supplies the expectation.
  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [4:0] motors;
  } stim_row_t;

  stim_row_t stim_table [$];

  // Works out the results for one accepted item and queues them. The state
  // follows the spec: a reply is only built when none is pending, M falls
  // through to the status reply, and a transmit leaves the reply pending.
  task automatic respond_to_item(input in_item_t it, input bit typed,
                                 input logic [4:0] typed_motors);
    out_item_t r;
    case (it.kind)
      KIND_COMMAND: begin
        if (reply_len == 4'd0) begin
          reply_bytes[0] = own_addr_reg;
          reply_bytes[1] = it.sender;
        end
        case (it.command)
          CMD_VERSION: begin
            if (reply_len == 4'd0) begin
              reply_len      = LEN_VERSION;
              reply_bytes[2] = CMD_VERSION;
              reply_bytes[3] = version_reg;
            end
          end
          CMD_ECHO: begin
            if (reply_len == 4'd0) begin
              reply_len      = LEN_ECHO;
              reply_bytes[2] = CMD_ECHO;
            end
          end
          CMD_MOTOR: begin
            // The motors move even when a reply is still pending.
            motor_lines_now  = it.argument[4:0] & MOTOR_MASK;
            ticks_to_disable = timeout_reg;
          end
          CMD_ACK: reply_len = 4'd0;
          CMD_DUMP: begin
            if (reply_len == 4'd0) begin
              reply_len      = LEN_DUMP;
              reply_bytes[2] = CMD_DUMP;
              for (int i = 0; i < int'(ADC_REPORT); i++) begin
                reply_bytes[3 + i] = (i < ADC_BYTES) ? adc_bytes[i] : 8'h00;
              end
            end
          end
          default: ;
        endcase
        // M reports status exactly as S does, after the motors are set.
        if ((it.command == CMD_MOTOR || it.command == CMD_STATUS) &&
            reply_len == 4'd0) begin
          reply_len      = LEN_STATUS;
          reply_bytes[2] = CMD_STATUS;
          reply_bytes[3] = {3'b000, motor_lines_now};
        end
      end
      KIND_TICK: begin
        // A zero count means the timeout is off or already expired.
        if (ticks_to_disable != 8'd0) begin
          ticks_to_disable = ticks_to_disable - 8'd1;
          if (ticks_to_disable == 8'd0) motor_lines_now = 5'd0;
        end
      end
      KIND_ADC: begin
        // Samples from channels the block does not have are dropped.
        if (int'(it.adc_channel) < ADC_CHANNELS) begin
          adc_bytes[2 * int'(it.adc_channel)]     = it.adc_high;
          adc_bytes[2 * int'(it.adc_channel) + 1] = it.adc_low;
        end
      end
      default: begin
        // Transmit opportunity: length byte, then the reply, last flag on
        // the final byte. With nothing pending it falls to the idle result.
        if (reply_len != 4'd0) begin
          r = '{motor_lines_now, 1'b1, {4'h0, reply_len}, 1'b0};
          responses_due.push_back(r);
          for (int k = 0; k < int'(reply_len); k++) begin
            r = '{motor_lines_now, 1'b1, reply_bytes[k], k == int'(reply_len) - 1};
            responses_due.push_back(r);
          end
          return;
        end
      end
    endcase
    r = '{typed ? typed_motors : motor_lines_now, 1'b0, 8'h00, 1'b0};
    responses_due.push_back(r);
  endtask

  // Presents one item and holds it until the block takes it. The sender
  // runs in bursts: when a burst is used up, valid drops for a random gap.
  task automatic send_item(input in_item_t it, input bit typed,
                           input logic [4:0] typed_motors);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    respond_to_item(it, typed, typed_motors);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Lowers valid and waits for every owed result, then lets the block settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write per clock; the shadow copy changes at the same edge.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_OWN_ADDRESS:   own_addr_reg = val;
      REG_MOTOR_TIMEOUT: timeout_reg  = val;
      default:           version_reg  = val;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] addr, input logic [7:0] ticks,
                               input logic [7:0] version);
    write_reg(REG_OWN_ADDRESS, addr);
    write_reg(REG_MOTOR_TIMEOUT, ticks);
    write_reg(REG_PROTO_VERSION, version);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t item_of(input logic [1:0] kind, input logic [7:0] sender,
                                       input logic [7:0] command,
                                       input logic [7:0] argument,
                                       input logic [2:0] chan, input logic [7:0] hi,
                                       input logic [7:0] lo);
    in_item_t it;
    it.kind        = kind;
    it.sender      = sender;
    it.command     = command;
    it.argument    = argument;
    it.adc_channel = chan;
    it.adc_high    = hi;
    it.adc_low     = lo;
    return it;
  endfunction

  // Every field random; fields that the kind does not use stay random too,
  // so the block is seen to ignore them.
  function automatic in_item_t random_item(input logic [1:0] kind);
    return item_of(kind, 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] known_command();
    case ($urandom_range(0, 5))
      0:       return CMD_VERSION;
      1:       return CMD_ECHO;
      2:       return CMD_MOTOR;
      3:       return CMD_STATUS;
      4:       return CMD_ACK;
      default: return CMD_DUMP;
    endcase
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed,
                                  input logic [4:0] motors);
    stim_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.motors = motors;
    stim_table.push_back(row);
  endfunction

  // Random traffic. The largest share is well-formed exchanges: a known command,
  // zero to two transmit opportunities, then usually an acknowledge so the
  // next command can build a fresh reply. Tick runs are long enough to let
  // short motor timeouts expire. The rest is ADC samples and noise.
  task automatic run_random(input int n_items);
    int       sent;
    int       pick;
    int       run_len;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it = random_item(KIND_COMMAND);
        it.command = known_command();
        send_item(it, 1'b0, 5'd0);
        sent++;
        repeat ($urandom_range(0, 2)) begin
          send_item(random_item(KIND_TRANSMIT), 1'b0, 5'd0);
          sent++;
        end
        if ($urandom_range(0, 4) != 0) begin
          it = random_item(KIND_COMMAND);
          it.command = CMD_ACK;
          send_item(it, 1'b0, 5'd0);
          sent++;
        end
      end else if (pick < 62) begin
        run_len = (timeout_reg < 8'd16) ? $urandom_range(1, int'(timeout_reg) + 2)
                                        : $urandom_range(1, 6);
        repeat (run_len) begin
          send_item(random_item(KIND_TICK), 1'b0, 5'd0);
          sent++;
        end
      end else if (pick < 77) begin
        it = random_item(KIND_ADC);
        send_item(it, 1'b0, 5'd0);
        sent++;
      end else begin
        // Noise: any kind, with a command byte that is as often garbage as
        // a real code.
        it = random_item(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) it.command = known_command();
        send_item(it, 1'b0, 5'd0);
        sent++;
      end
    end
  endtask

  // Receiver: mostly ready with short random stalls; at the start of each
  // pattern period it picks, one time in three, to never stall for that period.
  always @(posedge clk) begin
    if (rx_cycle % 256 == 0) rx_free = ($urandom_range(0, 2) == 0);
    rx_cycle++;
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  // Result checker and hang watchdog. Every accepted result is matched to
  // the oldest owed one, field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (responses_due.size() == 0) begin
        $error("unexpected result: motor_lines %0h tx_valid %0b tx_byte %0h tx_last %0b",
               out_item.motor_lines, out_item.tx_valid, out_item.tx_byte,
               out_item.tx_last);
        fail_count++;
      end else begin
        want = responses_due.pop_front();
        if (out_item.motor_lines !== want.motor_lines) begin
          $error("motor_lines: expected %0h, got %0h", want.motor_lines,
                 out_item.motor_lines);
          fail_count++;
        end
        if (out_item.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %0b, got %0b", want.tx_valid, out_item.tx_valid);
          fail_count++;
        end
        if (out_item.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, out_item.tx_byte);
          fail_count++;
        end
        if (out_item.tx_last !== want.tx_last) begin
          $error("tx_last: expected %0b, got %0b", want.tx_last, out_item.tx_last);
          fail_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // Shadow state after reset: registers at their reset values, no reply
    // pending, motors off, the ADC store reading as zero.
    own_addr_reg     = OWN_ADDRESS_RST;
    timeout_reg      = MOTOR_TIMEOUT_RST;
    version_reg      = PROTO_VERSION_RST;
    motor_lines_now  = 5'd0;
    ticks_to_disable = 8'd0;
    reply_len        = 4'd0;
    foreach (reply_bytes[i]) reply_bytes[i] = 8'h00;
    foreach (adc_bytes[i]) adc_bytes[i] = 8'h00;

    // Directed table, run with the registers at their reset values.
    // A tick with a zero countdown, and a transmit with nothing pending.
    add_row(item_of(KIND_TICK, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    // Version reply, then a second V while it is pending builds nothing.
    add_row(item_of(KIND_COMMAND, 8'hFF, CMD_VERSION, 8'h00, 3'd0, 8'h00, 8'h00),
            1'b1, 5'h00);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_VERSION, 8'h00, 3'd0, 8'h00, 8'h00),
            1'b1, 5'h00);
    add_row(item_of(KIND_TRANSMIT, 8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF, 8'hFF), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ACK, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    // Echo reply; an M while it is pending still drives all motor lines.
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ECHO, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h12, CMD_MOTOR, 8'hFF, 3'd0, 8'h00, 8'h00), 1'b1, 5'h1F);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ACK, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h1F);
    // M with only high argument bits set turns the motors off and reports.
    add_row(item_of(KIND_COMMAND, 8'h34, CMD_MOTOR, 8'hE0, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ACK, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h00);
    // M builds a status reply; an S while it is pending builds nothing.
    add_row(item_of(KIND_COMMAND, 8'h56, CMD_MOTOR, 8'h15, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);
    add_row(item_of(KIND_COMMAND, 8'h78, CMD_STATUS, 8'h00, 3'd0, 8'h00, 8'h00),
            1'b1, 5'h15);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ACK, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);
    // Samples on the first and last channel, and one on channel 7, beyond
    // the last channel, that must be dropped.
    add_row(item_of(KIND_ADC, 8'h00, 8'h00, 8'h00, 3'd0, 8'hFF, 8'h00), 1'b1, 5'h15);
    add_row(item_of(KIND_ADC, 8'h00, 8'h00, 8'h00, 3'd4, 8'h00, 8'hFF), 1'b1, 5'h15);
    add_row(item_of(KIND_ADC, 8'h00, 8'h00, 8'h00, 3'd7, 8'hAA, 8'h55), 1'b1, 5'h15);
    // Unknown command bytes at both ends of the range are ignored.
    add_row(item_of(KIND_COMMAND, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);
    add_row(item_of(KIND_COMMAND, 8'h00, 8'hFF, 8'hFF, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);
    // Full ADC dump, with channels never sampled reading as zero.
    add_row(item_of(KIND_COMMAND, 8'h5A, CMD_DUMP, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);
    add_row(item_of(KIND_TRANSMIT, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00), 1'b0, 5'h00);
    add_row(item_of(KIND_COMMAND, 8'h00, CMD_ACK, 8'h00, 3'd0, 8'h00, 8'h00), 1'b1, 5'h15);

    // Reset is applied once at the start and released at a clock edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].motors);
    end
    run_random(80);

    // Register settings, each applied while the block is idle: both
    // extremes of every register, a one-tick timeout, a timeout that never
    // expires in practice, and two random settings with short timeouts.
    drain_block();
    set_registers(8'hFF, 8'd0, 8'hFF);
    run_random(84);
    drain_block();
    set_registers(8'h00, 8'd1, 8'h00);
    run_random(84);
    drain_block();
    set_registers(8'($urandom), 8'($urandom_range(2, 12)), 8'($urandom));
    run_random(84);
    drain_block();
    set_registers(8'hA5, 8'd255, 8'h5A);
    run_random(84);
    drain_block();
    set_registers(8'($urandom), 8'($urandom_range(0, 6)), 8'($urandom));
    run_random(84);
    drain_block();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
